@@ hdl/m3inv_pkg.sv @@
// m3inv_pkg: types, widths and constants of the 3x3 matrix inverse core
// used by hdl/matrix3_inverse_core.sv; no dependencies
package m3inv_pkg;

   localparam int IN_W    = 24;
   localparam int OUT_W   = 32;
   localparam int LIMIT_W = 40;
   localparam int PROD_W  = 2 * IN_W;
   localparam int COF_W   = PROD_W + 1;
   localparam int LO_W    = IN_W;
   localparam int HI_W    = COF_W - LO_W;
   localparam int TERM_W  = IN_W + COF_W + 2;
   localparam int DET_W   = TERM_W;
   localparam int D2_W    = DET_W + 1;
   localparam int QBITS   = OUT_W;
   localparam int REM_W   = D2_W + QBITS;
   localparam int FRONT   = 8;
   localparam int LATENCY = FRONT + QBITS + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);
   localparam logic [OUT_W-1:0]   MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0]   MAX_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   // cofactor k = m[A]*m[B] - m[C]*m[D], adjugate order
   localparam logic [3:0] COF_A [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] COF_B [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] COF_C [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] COF_D [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   typedef struct packed {
      logic signed [IN_W-1:0] m_00;
      logic signed [IN_W-1:0] m_01;
      logic signed [IN_W-1:0] m_02;
      logic signed [IN_W-1:0] m_10;
      logic signed [IN_W-1:0] m_11;
      logic signed [IN_W-1:0] m_12;
      logic signed [IN_W-1:0] m_20;
      logic signed [IN_W-1:0] m_21;
      logic signed [IN_W-1:0] m_22;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inv_00;
      logic signed [OUT_W-1:0] inv_01;
      logic signed [OUT_W-1:0] inv_02;
      logic signed [OUT_W-1:0] inv_10;
      logic signed [OUT_W-1:0] inv_11;
      logic signed [OUT_W-1:0] inv_12;
      logic signed [OUT_W-1:0] inv_20;
      logic signed [OUT_W-1:0] inv_21;
      logic signed [OUT_W-1:0] inv_22;
      logic                    singular;
      logic                    saturated;
   } rsp_word_type;

endpackage

@@ hdl/matrix3_inverse_core.sv @@
// matrix3_inverse_core: pipelined 3x3 matrix inverse by adjugate over determinant
// depends on hdl/m3inv_pkg.sv
//
//  channel   ports                        direction  handshake
//  request   start, busy, req_word        in         taken when start & !busy
//  response  rsp_strobe, rsp_word         out        one-cycle strobe, no back pressure
//  config    csr_wr_en, csr_wr_data       in         written when csr_wr_en
//
// one matrix enters per cycle; each word passes through the pipeline after it is taken:
// 8 stages of products, cofactors, determinant and
//   numerators, then one restoring-divide stage per quotient bit (32), then output
// busy stays low: the pipeline never stalls since the receiver takes every word
// reset is synchronous and clears the valid bits and the limit register (to 1)
module matrix3_inverse_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  m3inv_pkg::req_word_type       req_word,
   output logic                          rsp_strobe,
   output m3inv_pkg::rsp_word_type       rsp_word,
   input  logic                          csr_wr_en,
   input  logic [m3inv_pkg::LIMIT_W-1:0] csr_wr_data
);

   localparam int NSTG = m3inv_pkg::LATENCY;
   localparam int NDIV = m3inv_pkg::QBITS;

   logic                                   take;
   logic [NSTG-1:0]                        vld_ff;
   logic [m3inv_pkg::LIMIT_W-1:0]          limit_ff;

   logic signed [m3inv_pkg::IN_W-1:0]      m_ff    [9];
   logic signed [m3inv_pkg::PROD_W-1:0]    pa_ff   [9];
   logic signed [m3inv_pkg::PROD_W-1:0]    pb_ff   [9];
   logic signed [m3inv_pkg::IN_W-1:0]      r0a_ff  [3];
   logic signed [m3inv_pkg::IN_W-1:0]      r0b_ff  [3];
   logic signed [m3inv_pkg::COF_W-1:0]     cof_ff  [9];
   logic signed [m3inv_pkg::COF_W-1:0]     cofb_ff [9];
   logic signed [m3inv_pkg::COF_W-1:0]     cofc_ff [9];
   logic signed [m3inv_pkg::COF_W-1:0]     cofd_ff [9];
   logic signed [m3inv_pkg::IN_W+m3inv_pkg::HI_W-1:0] dhi_ff [3];
   logic signed [m3inv_pkg::IN_W+m3inv_pkg::LO_W:0]   dlo_ff [3];
   logic signed [m3inv_pkg::TERM_W-1:0]    term_ff [3];
   logic signed [m3inv_pkg::DET_W-1:0]     det_ff;
   logic [m3inv_pkg::DET_W-1:0]            dabs_ff;
   logic                                   dneg_ff;
   logic [m3inv_pkg::COF_W-1:0]            cabs_ff [9];
   logic [8:0]                             cneg_ff;

   logic [m3inv_pkg::REM_W-1:0]            rem_ff  [NDIV+1][9];
   logic [m3inv_pkg::QBITS-1:0]            quo_ff  [NDIV+1][9];
   logic [m3inv_pkg::D2_W-1:0]             d2_ff   [NDIV+1];
   logic [8:0]                             neg_ff  [NDIV+1];
   logic [8:0]                             big_ff  [NDIV+1];
   logic                                   sing_ff [NDIV+1];

   logic [m3inv_pkg::OUT_W-1:0]            res     [9];
   logic [8:0]                             clip;
   m3inv_pkg::rsp_word_type                rsp_in;
   m3inv_pkg::rsp_word_type                rsp_ff;

   assign take = start & ~busy;
   assign busy = 1'b0;

   // valid bits and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         limit_ff <= m3inv_pkg::LIMIT_RESET;
      end else begin
         vld_ff <= {vld_ff[NSTG-2:0], take};
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // front end: input, products, cofactors, determinant, numerators
   always_ff @(posedge clock) begin
      m_ff[0] <= req_word.m_00;  m_ff[1] <= req_word.m_01;  m_ff[2] <= req_word.m_02;
      m_ff[3] <= req_word.m_10;  m_ff[4] <= req_word.m_11;  m_ff[5] <= req_word.m_12;
      m_ff[6] <= req_word.m_20;  m_ff[7] <= req_word.m_21;  m_ff[8] <= req_word.m_22;
      for (int k = 0; k < 9; k++) begin
         pa_ff[k] <= m_ff[m3inv_pkg::COF_A[k]] * m_ff[m3inv_pkg::COF_B[k]];
         pb_ff[k] <= m_ff[m3inv_pkg::COF_C[k]] * m_ff[m3inv_pkg::COF_D[k]];
         cof_ff[k] <= m3inv_pkg::COF_W'(pa_ff[k]) - m3inv_pkg::COF_W'(pb_ff[k]);
         cofb_ff[k] <= cof_ff[k];
         cofc_ff[k] <= cofb_ff[k];
         cofd_ff[k] <= cofc_ff[k];
      end
      for (int j = 0; j < 3; j++) begin
         r0a_ff[j] <= m_ff[j];
         r0b_ff[j] <= r0a_ff[j];
         // split each of cofactors 0, 3 and 6 into a signed high and unsigned low half
         dhi_ff[j] <= r0b_ff[j]
                      * $signed(cof_ff[3*j][m3inv_pkg::COF_W-1:m3inv_pkg::LO_W]);
         dlo_ff[j] <= r0b_ff[j] * $signed({1'b0, cof_ff[3*j][m3inv_pkg::LO_W-1:0]});
         term_ff[j] <= (m3inv_pkg::TERM_W'(dhi_ff[j]) <<< m3inv_pkg::LO_W)
                       + m3inv_pkg::TERM_W'(dlo_ff[j]);
      end
      det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
      dneg_ff <= det_ff[m3inv_pkg::DET_W-1];
      dabs_ff <= det_ff[m3inv_pkg::DET_W-1] ? -det_ff : det_ff;
      // cofactor magnitudes land in the same stage as the determinant magnitude
      for (int k = 0; k < 9; k++) begin
         cneg_ff[k] <= cofd_ff[k][m3inv_pkg::COF_W-1];
         cabs_ff[k] <= cofd_ff[k][m3inv_pkg::COF_W-1] ? -cofd_ff[k] : cofd_ff[k];
      end
      // numerator 2|c|*2^32 + |det|, divisor 2|det|
      d2_ff[0]   <= {dabs_ff, 1'b0};
      sing_ff[0] <= (dabs_ff == '0)
                    || (dabs_ff < m3inv_pkg::DET_W'(limit_ff));
      for (int k = 0; k < 9; k++) begin
         rem_ff[0][k] <= (m3inv_pkg::REM_W'(cabs_ff[k]) << (m3inv_pkg::QBITS + 1))
                         + m3inv_pkg::REM_W'(dabs_ff);
         big_ff[0][k] <= (m3inv_pkg::REM_W'(cabs_ff[k]) << (m3inv_pkg::QBITS + 1))
                         + m3inv_pkg::REM_W'(dabs_ff)
                         >= (m3inv_pkg::REM_W'({dabs_ff, 1'b0}) << m3inv_pkg::QBITS);
         neg_ff[0][k] <= cneg_ff[k] ^ dneg_ff;
         quo_ff[0][k] <= '0;
      end
   end

   // restoring divide, one quotient bit per stage, msb first
   always_ff @(posedge clock) begin
      for (int s = 1; s <= NDIV; s++) begin
         d2_ff[s]   <= d2_ff[s-1];
         sing_ff[s] <= sing_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         big_ff[s]  <= big_ff[s-1];
         for (int k = 0; k < 9; k++) begin
            if (rem_ff[s-1][k] >= (m3inv_pkg::REM_W'(d2_ff[s-1]) << (NDIV - s))) begin
               rem_ff[s][k] <= rem_ff[s-1][k]
                               - (m3inv_pkg::REM_W'(d2_ff[s-1]) << (NDIV - s));
               quo_ff[s][k] <= {quo_ff[s-1][k][m3inv_pkg::QBITS-2:0], 1'b1};
            end else begin
               rem_ff[s][k] <= rem_ff[s-1][k];
               quo_ff[s][k] <= {quo_ff[s-1][k][m3inv_pkg::QBITS-2:0], 1'b0};
            end
         end
      end
   end

   // sign, saturation and singular masking
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         clip[k] = 1'b0;
         if (sing_ff[NDIV]) begin
            res[k] = '0;
         end else if (neg_ff[NDIV][k]) begin
            if (big_ff[NDIV][k] || (quo_ff[NDIV][k] > m3inv_pkg::MAX_NEG)) begin
               res[k]  = m3inv_pkg::MAX_NEG;
               clip[k] = 1'b1;
            end else begin
               res[k] = -quo_ff[NDIV][k];
            end
         end else begin
            if (big_ff[NDIV][k] || (quo_ff[NDIV][k] > m3inv_pkg::MAX_POS)) begin
               res[k]  = m3inv_pkg::MAX_POS;
               clip[k] = 1'b1;
            end else begin
               res[k] = quo_ff[NDIV][k];
            end
         end
      end
      rsp_in.inv_00    = res[0];
      rsp_in.inv_01    = res[1];
      rsp_in.inv_02    = res[2];
      rsp_in.inv_10    = res[3];
      rsp_in.inv_11    = res[4];
      rsp_in.inv_12    = res[5];
      rsp_in.inv_20    = res[6];
      rsp_in.inv_21    = res[7];
      rsp_in.inv_22    = res[8];
      rsp_in.singular  = sing_ff[NDIV];
      rsp_in.saturated = |clip;
   end

   // output word register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_word   = rsp_ff;
   assign rsp_strobe = vld_ff[NSTG-1];

   // every taken word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(NSTG) rsp_strobe)
      else $error("word lost in pipeline");

   // a singular word carries zero entries inv_00, inv_01, inv_11, inv_20, inv_22 and no clip flag
   a_singular: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.singular) |->
         (!rsp_word.saturated && rsp_word.inv_00 == '0 && rsp_word.inv_11 == '0
          && rsp_word.inv_22 == '0 && rsp_word.inv_01 == '0 && rsp_word.inv_20 == '0))
      else $error("singular word with nonzero entries");

   // no strobe right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe after reset");

endmodule

@@ tb/sv/matrix3_inverse_checker.sv @@
// matrix3_inverse_checker: predicts the inverse of every taken matrix and compares it
// with the words that leave matrix3_inverse_core; depends on hdl/m3inv_pkg.sv
module matrix3_inverse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  m3inv_pkg::req_word_type       req_word,
   input  logic                          rsp_strobe,
   input  m3inv_pkg::rsp_word_type       rsp_word,
   input  logic                          csr_wr_en,
   input  logic [m3inv_pkg::LIMIT_W-1:0] csr_wr_data,
   output int                            error_count,
   output int                            pending_count
);

   m3inv_pkg::rsp_word_type       inverse_queue[$];
   logic [m3inv_pkg::LIMIT_W-1:0] limit_shadow;

   // exact adjugate over determinant, rounded to nearest, saturated; singular if |det| is 0 or below limit
   function automatic m3inv_pkg::rsp_word_type predict_inverse(
         m3inv_pkg::req_word_type w, logic [m3inv_pkg::LIMIT_W-1:0] lim);
      logic signed [127:0]         m [9];
      logic signed [127:0]         cf [9];
      logic signed [127:0]         det, dabs, num, q;
      logic [m3inv_pkg::OUT_W-1:0] ent [9];
      logic                        neg, sat;
      m3inv_pkg::rsp_word_type     r;
      m = '{w.m_00, w.m_01, w.m_02, w.m_10, w.m_11, w.m_12, w.m_20, w.m_21, w.m_22};
      cf[0] = m[4]*m[8] - m[5]*m[7];
      cf[1] = m[2]*m[7] - m[1]*m[8];
      cf[2] = m[1]*m[5] - m[2]*m[4];
      cf[3] = m[5]*m[6] - m[3]*m[8];
      cf[4] = m[0]*m[8] - m[2]*m[6];
      cf[5] = m[2]*m[3] - m[0]*m[5];
      cf[6] = m[3]*m[7] - m[4]*m[6];
      cf[7] = m[1]*m[6] - m[0]*m[7];
      cf[8] = m[0]*m[4] - m[1]*m[3];
      det  = m[0]*cf[0] + m[1]*cf[3] + m[2]*cf[6];
      dabs = det < 0 ? -det : det;
      r = '0;
      if (dabs == 0 || dabs < $signed({88'd0, lim})) begin
         r.singular = 1'b1;
         return r;
      end
      sat = 1'b0;
      for (int k = 0; k < 9; k++) begin
         neg = (cf[k] < 0) != (det < 0);
         num = ((cf[k] < 0 ? -cf[k] : cf[k]) <<< 33) + dabs;
         q   = num / (dabs <<< 1);
         if (neg) begin
            if (q > 128'sh8000_0000) begin
               q = 128'sh8000_0000;
               sat = 1'b1;
            end
            ent[k] = -q[m3inv_pkg::OUT_W-1:0];
         end else begin
            if (q > 128'sh7fff_ffff) begin
               q = 128'sh7fff_ffff;
               sat = 1'b1;
            end
            ent[k] = q[m3inv_pkg::OUT_W-1:0];
         end
      end
      r = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
           1'b0, sat};
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [m3inv_pkg::OUT_W-1:0] got,
                                  logic [m3inv_pkg::OUT_W-1:0] want);
      $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // watch the channels at each edge
   always @(posedge clock) begin
      m3inv_pkg::rsp_word_type want;
      if (reset) begin
         limit_shadow <= m3inv_pkg::LIMIT_RESET;
         inverse_queue.delete();
         error_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (inverse_queue.size() == 0) begin
               report_mismatch("unexpected word", '0, '0);
            end else begin
               want = inverse_queue.pop_front();
               if (rsp_word.inv_00 !== want.inv_00)
                  report_mismatch("inv_00", rsp_word.inv_00, want.inv_00);
               if (rsp_word.inv_01 !== want.inv_01)
                  report_mismatch("inv_01", rsp_word.inv_01, want.inv_01);
               if (rsp_word.inv_02 !== want.inv_02)
                  report_mismatch("inv_02", rsp_word.inv_02, want.inv_02);
               if (rsp_word.inv_10 !== want.inv_10)
                  report_mismatch("inv_10", rsp_word.inv_10, want.inv_10);
               if (rsp_word.inv_11 !== want.inv_11)
                  report_mismatch("inv_11", rsp_word.inv_11, want.inv_11);
               if (rsp_word.inv_12 !== want.inv_12)
                  report_mismatch("inv_12", rsp_word.inv_12, want.inv_12);
               if (rsp_word.inv_20 !== want.inv_20)
                  report_mismatch("inv_20", rsp_word.inv_20, want.inv_20);
               if (rsp_word.inv_21 !== want.inv_21)
                  report_mismatch("inv_21", rsp_word.inv_21, want.inv_21);
               if (rsp_word.inv_22 !== want.inv_22)
                  report_mismatch("inv_22", rsp_word.inv_22, want.inv_22);
               if (rsp_word.singular !== want.singular)
                  report_mismatch("singular", m3inv_pkg::OUT_W'(rsp_word.singular),
                                  m3inv_pkg::OUT_W'(want.singular));
               if (rsp_word.saturated !== want.saturated)
                  report_mismatch("saturated", m3inv_pkg::OUT_W'(rsp_word.saturated),
                                  m3inv_pkg::OUT_W'(want.saturated));
            end
         end
         if (start && !busy) inverse_queue.push_back(predict_inverse(req_word, limit_shadow));
         if (csr_wr_en) limit_shadow <= csr_wr_data;
      end
      pending_count = inverse_queue.size();
   end

endmodule

@@ tb/sv/matrix3_inverse_core_tb.sv @@
// matrix3_inverse_core_tb: drives matrices and limit settings into matrix3_inverse_core
// depends on hdl/m3inv_pkg.sv, hdl/matrix3_inverse_core.sv, tb/sv/matrix3_inverse_checker.sv
module matrix3_inverse_core_tb;

   localparam logic signed [m3inv_pkg::IN_W-1:0] ONE   = 24'sh01_0000;
   localparam logic signed [m3inv_pkg::IN_W-1:0] V_MAX = 24'sh7f_ffff;
   localparam logic signed [m3inv_pkg::IN_W-1:0] V_MIN = 24'sh80_0000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   m3inv_pkg::req_word_type       req_word;
   logic                          rsp_strobe;
   m3inv_pkg::rsp_word_type       rsp_word;
   logic                          csr_wr_en;
   logic [m3inv_pkg::LIMIT_W-1:0] csr_wr_data;
   int                            error_count;
   int                            pending_count;

   matrix3_inverse_core dut (.*);

   matrix3_inverse_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // random entry: often moderate values, sometimes full-range, extremes, zero or tiny ones
   function automatic logic signed [m3inv_pkg::IN_W-1:0] rand_entry();
      unique case ($urandom_range(0, 9))
         0: return V_MAX;
         1: return V_MIN;
         2: return '0;
         3: return m3inv_pkg::IN_W'(int'($urandom_range(0, 15)) - 8);
         4, 5: return m3inv_pkg::IN_W'($urandom);
         default: return $signed(m3inv_pkg::IN_W'($urandom_range(0, 24'h7ffff)))
                         - 24'sh4_0000;
      endcase
   endfunction

   function automatic m3inv_pkg::req_word_type rand_matrix();
      m3inv_pkg::req_word_type w;
      w = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
           rand_entry(), rand_entry(), rand_entry(), rand_entry()};
      // sometimes make rows dependent to reach the singular path
      if ($urandom_range(0, 9) == 0) begin
         w.m_20 = w.m_00;
         w.m_21 = w.m_01;
         w.m_22 = w.m_02;
      end
      return w;
   endfunction

   // start stays high across back-to-back words and drops only for a gap
   task automatic send_word(m3inv_pkg::req_word_type w);
      int idle;
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (m3inv_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [m3inv_pkg::LIMIT_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_diag(logic signed [m3inv_pkg::IN_W-1:0] a,
                            logic signed [m3inv_pkg::IN_W-1:0] b,
                            logic signed [m3inv_pkg::IN_W-1:0] c);
      send_word({a, 24'sd0, 24'sd0, 24'sd0, b, 24'sd0, 24'sd0, 24'sd0, c});
   endtask

   // limit settings per random phase (the last phase uses a random value), the extremes among them
   logic [m3inv_pkg::LIMIT_W-1:0] limits [6] = '{40'd0, 40'd1, 40'hff_ffff_ffff,
                                                 40'h1_0000_0000, 40'd12345, 40'd1};

   initial begin
      m3inv_pkg::req_word_type w;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_word    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, extremes, zero, tiny determinant, saturation, ties
      send_diag(ONE, ONE, ONE);
      send_diag(-ONE, ONE, -ONE);
      send_diag(V_MAX, V_MAX, V_MAX);
      send_diag(V_MIN, V_MIN, V_MIN);
      send_diag(V_MIN, V_MAX, 24'sd1);
      send_word('0);
      send_word({9{V_MAX}});
      send_word({9{24'sh00_0001}});
      send_diag(24'sd1, 24'sd1, 24'sd1);
      send_diag(24'sd1, 24'sd1, 24'sd2);
      send_diag(24'sd2, 24'sd1, 24'sd1);
      send_diag(24'sd3, ONE, ONE);
      send_diag(24'sd2, ONE, ONE);
      send_diag(-24'sd2, ONE, ONE);
      send_word({V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX});
      send_word({ONE, 24'sd2 * ONE, 24'sd3 * ONE, -ONE, 24'sd5, ONE, 24'sd4 * ONE,
                 24'sd0, -ONE});
      send_word({V_MIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0, V_MIN, 24'sd0, V_MIN, 24'sd0});
      write_limit(40'd0);
      send_word('0);
      send_diag(24'sd1, 24'sd1, 24'sd1);
      write_limit(40'd2);
      send_diag(24'sd1, 24'sd1, 24'sd1);
      send_diag(24'sd1, 24'sd1, 24'sd2);

      // random phases, each under its own limit
      foreach (limits[p]) begin
         write_limit(p == 5 ? m3inv_pkg::LIMIT_W'({$urandom, $urandom}) : limits[p]);
         for (int i = 0; i < 205; i++) begin
            w = rand_matrix();
            if ($urandom_range(0, 7) == 0)
               w = {w.m_00, 24'sd0, 24'sd0, 24'sd0, w.m_11, 24'sd0, 24'sd0, 24'sd0,
                    $signed(m3inv_pkg::IN_W'($urandom_range(0, 4)))};
            send_word(w);
         end
      end

      drain();
      if (error_count == 0)
         $display("matrix3_inverse_core_tb passed");
      else
         $display("matrix3_inverse_core_tb failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("matrix3_inverse_core_tb failed");
      $finish;
   end

endmodule

@@ matrix3_inverse_core.f @@
hdl/m3inv_pkg.sv
hdl/matrix3_inverse_core.sv
tb/sv/matrix3_inverse_checker.sv
tb/sv/matrix3_inverse_core_tb.sv
